/* rtl/wfc_pkg.sv */
// shared types, constants and helpers for the word frequency counter
`timescale 1ns / 1ps

package wfc_pkg;

	localparam int BYTE_W     = 8;
	localparam int COUNT_W    = 10;
	localparam int SLOT_W     = 5;
	localparam int DISTINCT_W = 6;

	localparam logic [COUNT_W-1:0] COUNT_MAX  = 10'd1023;
	localparam logic [BYTE_W-1:0]  APOSTROPHE = 8'h27;
	localparam logic [BYTE_W-1:0]  NUL_CHAR   = 8'h00;

	localparam int DEF_TABLE_WORDS = 32;
	localparam int DEF_WORD_CHARS  = 64;
	localparam int DEF_INPUT_CHARS = 1024;

	// what each cell does with the byte read at the beat position
	typedef enum logic [2:0] {
		OP_NONE,        // no compare
		OP_FIRST,       // first char of a word: match = eq
		OP_NEXT,        // match = match & eq
		OP_APOS_SET,    // tentative apostrophe: apos match = match & eq
		OP_APOS_KEEP,   // apostrophe past the truncation point: apos match = match
		OP_RESUME,      // apostrophe kept: match = apos match & eq
		OP_RESUME_KEEP  // apostrophe kept, char truncated: match = apos match
	} cell_op_t;

	typedef struct packed {
		cell_op_t            op;
		logic [BYTE_W-1:0]   chr;
		logic                finish;
		logic                eot;
	} scan_evt_t;

	typedef struct packed {
		logic adv;      // stage one beat completes
		logic commit;   // a word ends and the text has not failed
		logic clear;    // end of text: drop the table
	} cell_ctl_t;

	function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
		return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
	endfunction

	function automatic logic op_writes(input cell_op_t op);
		return op == OP_FIRST || op == OP_NEXT || op == OP_APOS_SET || op == OP_RESUME;
	endfunction

endpackage

/* rtl/wfc_scan.sv */
// byte scanner: word boundaries, apostrophe hold, truncation and text position
`timescale 1ns / 1ps

module wfc_scan #(
	parameter int WORD_CHARS  = wfc_pkg::DEF_WORD_CHARS,
	parameter int INPUT_CHARS = wfc_pkg::DEF_INPUT_CHARS,
	localparam int LW = $clog2(WORD_CHARS),
	localparam int PW = $clog2(INPUT_CHARS)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [wfc_pkg::BYTE_W-1:0] text_byte,
	input  logic                       byte_valid,
	input  logic                       end_of_text,
	output wfc_pkg::scan_evt_t         evt,
	output logic [LW-1:0]              wpos,
	output logic [LW-1:0]              flen
);

	localparam logic [LW-1:0] LEN_MAX = LW'(WORD_CHARS - 1);
	localparam logic [PW-1:0] POS_MAX = PW'(INPUT_CHARS - 1);

	logic          in_word_q, apos_q;
	logic [LW-1:0] len_q;
	logic [PW-1:0] pos_q;

	logic          in_word_n, apos_n;
	logic [LW-1:0] len_n, len1;
	logic [PW-1:0] pos_n;
	logic          take, room, room1, fin_word;

	always_comb begin
		take      = byte_valid && (pos_q < POS_MAX);
		room      = len_q < LEN_MAX;
		len1      = len_q + LW'(room);
		room1     = len1 < LEN_MAX;
		in_word_n = in_word_q;
		apos_n    = apos_q;
		len_n     = len_q;
		pos_n     = pos_q;
		fin_word  = 1'b0;
		wpos      = len_q;
		evt.op    = wfc_pkg::OP_NONE;
		evt.chr   = wfc_pkg::to_lower(text_byte);
		evt.eot   = end_of_text;
		if (take) begin
			pos_n = pos_q + PW'(1);
			if (text_byte == wfc_pkg::NUL_CHAR) begin
				pos_n    = POS_MAX;
				fin_word = in_word_q;
			end else if (wfc_pkg::is_alnum(text_byte)) begin
				in_word_n = 1'b1;
				if (apos_q) begin
					apos_n = 1'b0;
					wpos   = len1;
					evt.op = room1 ? wfc_pkg::OP_RESUME : wfc_pkg::OP_RESUME_KEEP;
					len_n  = len1 + LW'(room1);
				end else begin
					if (room)
						evt.op = in_word_q ? wfc_pkg::OP_NEXT : wfc_pkg::OP_FIRST;
					len_n = len_q + LW'(room);
				end
			end else if (text_byte == wfc_pkg::APOSTROPHE && in_word_q && !apos_q) begin
				apos_n  = 1'b1;
				evt.chr = wfc_pkg::APOSTROPHE;
				evt.op  = room ? wfc_pkg::OP_APOS_SET : wfc_pkg::OP_APOS_KEEP;
			end else begin
				fin_word = in_word_q;
			end
		end
		if (fin_word) begin
			in_word_n = 1'b0;
			apos_n    = 1'b0;
			len_n     = '0;
		end
		flen       = fin_word ? len_q : len_n;
		evt.finish = fin_word || (end_of_text && in_word_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
			apos_q    <= 1'b0;
			len_q     <= '0;
			pos_q     <= '0;
		end else if (accept) begin
			if (end_of_text) begin
				in_word_q <= 1'b0;
				apos_q    <= 1'b0;
				len_q     <= '0;
				pos_q     <= '0;
			end else begin
				in_word_q <= in_word_n;
				apos_q    <= apos_n;
				len_q     <= len_n;
				pos_q     <= pos_n;
			end
		end
	end

endmodule

/* rtl/wfc_cell.sv */
// one table entry: stored word, length, count and a running match against the word in flight
`timescale 1ns / 1ps

module wfc_cell #(
	parameter int WORD_CHARS = wfc_pkg::DEF_WORD_CHARS,
	localparam int LW = $clog2(WORD_CHARS),
	localparam int AW = (WORD_CHARS > 2) ? $clog2(WORD_CHARS - 1) : 1
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [LW-1:0]               rd_pos,
	input  wfc_pkg::scan_evt_t          evt_s1,
	input  logic [LW-1:0]               wpos_s1,
	input  logic [LW-1:0]               flen_s1,
	input  wfc_pkg::cell_ctl_t          ctl,
	input  logic                        is_free,
	input  logic                        insert,
	output logic                        hit,
	output logic [wfc_pkg::COUNT_W-1:0] count
);

	logic [wfc_pkg::BYTE_W-1:0]  mem [WORD_CHARS-1];
	logic [wfc_pkg::BYTE_W-1:0]  rd_q;
	logic                        used_q, match_q, apos_match_q;
	logic [LW-1:0]               len_q;
	logic [wfc_pkg::COUNT_W-1:0] cnt_q;
	logic                        eq, match_n, apos_match_n, wen;

	assign wen   = ctl.adv && is_free && wfc_pkg::op_writes(evt_s1.op);
	assign eq    = rd_q == evt_s1.chr;
	assign count = cnt_q;

	always_comb begin
		match_n      = match_q;
		apos_match_n = apos_match_q;
		case (evt_s1.op)
			wfc_pkg::OP_NONE:        ;
			wfc_pkg::OP_FIRST:       match_n      = eq;
			wfc_pkg::OP_NEXT:        match_n      = match_q & eq;
			wfc_pkg::OP_APOS_SET:    apos_match_n = match_q & eq;
			wfc_pkg::OP_APOS_KEEP:   apos_match_n = match_q;
			wfc_pkg::OP_RESUME:      match_n      = apos_match_q & eq;
			wfc_pkg::OP_RESUME_KEEP: match_n      = apos_match_q;
			default:                 ;
		endcase
		hit = used_q && match_n && (len_q == flen_s1);
	end

	// word store, write-first toward a read of the same byte
	always_ff @(posedge clk) begin
		if (wen)
			mem[wpos_s1[AW-1:0]] <= evt_s1.chr;
		if (rd_en)
			rd_q <= (wen && wpos_s1 == rd_pos) ? evt_s1.chr : mem[rd_pos[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ctl.adv) begin
			match_q      <= match_n;
			apos_match_q <= apos_match_n;
			if (insert) begin
				len_q <= flen_s1;
				cnt_q <= wfc_pkg::COUNT_W'(1);
			end else if (ctl.commit && hit && cnt_q != wfc_pkg::COUNT_MAX) begin
				cnt_q <= cnt_q + wfc_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (ctl.adv) begin
			if (ctl.clear)
				used_q <= 1'b0;
			else if (insert)
				used_q <= 1'b1;
		end
	end

endmodule

/* rtl/word_frequency_counter.sv */
// top level: byte scanner, row of word cells, table bookkeeping and result register
`timescale 1ns / 1ps

// Counts words in a byte stream. One text byte is taken per beat, and one beat can
// enter in every clock cycle while in_stall is low; a beat's result, if any, passes
// through stage one and the result register. The rate is set by the row of word
// cells: each cell keeps one distinct word in a small byte store of its own and
// compares it with the word in flight one character per beat, so a word end is
// resolved with no search over the table. A word is a run of ASCII letters and
// digits, lower-cased and cut to WORD_CHARS-1 characters; an apostrophe between two
// of them belongs to the word. A result comes out when a word is counted (slot, count
// after it, new mark), when a new word finds the table of TABLE_WORDS words full
// (table_overflow, and later words of that text are dropped) and on the end-of-text
// beat, which reports the number of distinct words and clears the table. Only the
// first INPUT_CHARS-1 bytes of a text count, and a zero byte ends the readable text.
// A stalled output holds the result and back-pressures the input after one more beat.
module word_frequency_counter #(
	parameter int TABLE_WORDS = wfc_pkg::DEF_TABLE_WORDS,
	parameter int WORD_CHARS  = wfc_pkg::DEF_WORD_CHARS,
	parameter int INPUT_CHARS = wfc_pkg::DEF_INPUT_CHARS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [wfc_pkg::BYTE_W-1:0]     text_byte,
	input  logic                           byte_valid,
	input  logic                           end_of_text,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           word_done,
	output logic [wfc_pkg::SLOT_W-1:0]     slot,
	output logic [wfc_pkg::COUNT_W-1:0]    word_total,
	output logic                           is_new,
	output logic                           text_done,
	output logic [wfc_pkg::DISTINCT_W-1:0] distinct_words,
	output logic                           table_overflow
);

	localparam int LW = $clog2(WORD_CHARS);
	localparam int EW = $clog2(TABLE_WORDS + 1);
	localparam int IW = (TABLE_WORDS > 1) ? $clog2(TABLE_WORDS) : 1;
	localparam logic [EW-1:0] ENT_MAX = EW'(TABLE_WORDS);

	// scanner output, before stage one
	wfc_pkg::scan_evt_t evt;
	logic [LW-1:0]      wpos, flen;

	// stage one
	logic               valid_s1;
	wfc_pkg::scan_evt_t evt_s1;
	logic [LW-1:0]      wpos_s1, flen_s1;

	// table bookkeeping
	logic [EW-1:0] entries_q;
	logic          failed_q;

	logic                        accept, out_free, adv;
	wfc_pkg::cell_ctl_t          ctl;
	logic [TABLE_WORDS-1:0]      hit, free_v, ins_v;
	logic [wfc_pkg::COUNT_W-1:0] cnt [TABLE_WORDS];
	logic                        any_hit, room, ins_ok, fail_now, done_now, failed_n, has_res;
	logic [IW-1:0]               hit_idx;
	logic [wfc_pkg::COUNT_W-1:0] hit_cnt, total;
	logic [EW-1:0]               entries_n;

	// result register
	logic                           word_done_q, is_new_q, text_done_q, overflow_q, out_valid_q;
	logic [wfc_pkg::SLOT_W-1:0]     slot_q;
	logic [wfc_pkg::COUNT_W-1:0]    total_q;
	logic [wfc_pkg::DISTINCT_W-1:0] distinct_q;

	// stage one moves on only when the result register can take its beat
	assign out_free = !out_valid_q || !out_stall;
	assign adv      = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept   = in_valid && !in_stall;

	wfc_scan #(
		.WORD_CHARS  (WORD_CHARS),
		.INPUT_CHARS (INPUT_CHARS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.text_byte   (text_byte),
		.byte_valid  (byte_valid),
		.end_of_text (end_of_text),
		.evt         (evt),
		.wpos        (wpos),
		.flen        (flen)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1  <= evt;
			wpos_s1 <= wpos;
			flen_s1 <= flen;
		end
	end

	// a word end while the text stands failed is dropped, as are the bytes before it
	assign ctl.adv    = adv;
	assign ctl.commit = evt_s1.finish && !failed_q;
	assign ctl.clear  = evt_s1.eot;

	always_comb begin
		for (int i = 0; i < TABLE_WORDS; i++)
			free_v[i] = entries_q == EW'(i);
	end

	assign any_hit  = |hit;
	assign room     = entries_q < ENT_MAX;
	assign ins_ok   = ctl.commit && !any_hit && room;
	assign fail_now = ctl.commit && !any_hit && !room;
	assign done_now = ctl.commit && (any_hit || room);
	assign ins_v    = ins_ok ? free_v : '0;

	for (genvar g = 0; g < TABLE_WORDS; g++) begin : g_cell
		wfc_cell #(
			.WORD_CHARS (WORD_CHARS)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.rd_en   (accept),
			.rd_pos  (wpos),
			.evt_s1  (evt_s1),
			.wpos_s1 (wpos_s1),
			.flen_s1 (flen_s1),
			.ctl     (ctl),
			.is_free (free_v[g]),
			.insert  (ins_v[g]),
			.hit     (hit[g]),
			.count   (cnt[g])
		);
	end

	// stored words are distinct, so at most one cell hits
	always_comb begin
		hit_idx = '0;
		hit_cnt = '0;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			if (hit[i]) begin
				hit_idx = hit_idx | IW'(i);
				hit_cnt = hit_cnt | cnt[i];
			end
		end
		total     = (hit_cnt == wfc_pkg::COUNT_MAX) ? hit_cnt
		                                            : hit_cnt + wfc_pkg::COUNT_W'(1);
		entries_n = entries_q + EW'(ins_ok);
		failed_n  = failed_q || fail_now;
		has_res   = done_now || fail_now || evt_s1.eot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			failed_q  <= 1'b0;
		end else if (adv) begin
			if (evt_s1.eot) begin
				entries_q <= '0;
				failed_q  <= 1'b0;
			end else begin
				entries_q <= entries_n;
				failed_q  <= failed_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv && has_res)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			word_done_q <= done_now;
			is_new_q    <= ins_ok;
			text_done_q <= evt_s1.eot;
			overflow_q  <= failed_n;
			if (!done_now) begin
				slot_q  <= '0;
				total_q <= '0;
			end else if (any_hit) begin
				slot_q  <= wfc_pkg::SLOT_W'(hit_idx);
				total_q <= total;
			end else begin
				slot_q  <= wfc_pkg::SLOT_W'(entries_q);
				total_q <= wfc_pkg::COUNT_W'(1);
			end
			distinct_q <= (evt_s1.eot && !failed_n) ? wfc_pkg::DISTINCT_W'(entries_n) : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign word_done      = word_done_q;
	assign slot           = slot_q;
	assign word_total     = total_q;
	assign is_new         = is_new_q;
	assign text_done      = text_done_q;
	assign distinct_words = distinct_q;
	assign table_overflow = overflow_q;

endmodule

/* rtl/wfc_checker.sv */
// port-level checks for the word frequency counter, bound to the top level
`timescale 1ns / 1ps

module wfc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic                           word_done,
	input logic [wfc_pkg::SLOT_W-1:0]     slot,
	input logic [wfc_pkg::COUNT_W-1:0]    word_total,
	input logic                           is_new,
	input logic                           text_done,
	input logic [wfc_pkg::DISTINCT_W-1:0] distinct_words,
	input logic                           table_overflow
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(slot) && $stable(word_total) &&
		$stable(word_done) && $stable(text_done) && $stable(distinct_words))
		else $error("result beat changed under stall");

	// a freshly inserted word has been seen once
	a_new_once: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_new |-> word_done && word_total == wfc_pkg::COUNT_W'(1))
		else $error("new word with count other than one");

	// word fields are zero on beats that count no word
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !word_done |-> slot == '0 && word_total == '0 && !is_new)
		else $error("word fields set without a counted word");

	// a failed text counts no word and reports no distinct total
	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_overflow |-> !word_done && distinct_words == '0)
		else $error("overflow beat carries word data");

	// a counted word always has a nonzero count
	a_total_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_done |-> word_total != '0)
		else $error("counted word with zero total");

endmodule

bind word_frequency_counter wfc_checker u_wfc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.word_done      (word_done),
	.slot           (slot),
	.word_total     (word_total),
	.is_new         (is_new),
	.text_done      (text_done),
	.distinct_words (distinct_words),
	.table_overflow (table_overflow)
);
